FILE: rtl/sre_pkg.sv
`default_nettype none

package sre_pkg;

    // frame geometry
    localparam int unsigned SRE_MAX_WIDTH    = 2048;
    localparam logic [11:0] SRE_WIDTH_RESET  = 12'd640;
    localparam logic [15:0] SRE_HEIGHT_RESET = 16'd480;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_index;

    // one rgb pixel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // 3x3 window, [row][col], col 2 newest, row 2 newest
    typedef t_rgb [2:0][2:0] t_window;

    // input transaction payload
    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    // output transaction payload
    typedef struct packed {
        logic [7:0] red_edge;
        logic [7:0] green_edge;
        logic [7:0] blue_edge;
        logic       frame_done;
    } t_pix_out;

endpackage

`default_nettype wire

FILE: rtl/sre_line_buffer.sv
`default_nettype none

module sre_line_buffer
    import sre_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = SRE_MAX_WIDTH
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rd_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    input  wire logic                         i_wr_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  wire t_rgb                         i_wr_px,
    output t_rgb                              o_up,
    output t_rgb                              o_mid
);

    // row two above and row one above
    t_rgb r_upper_mem  [MAX_WIDTH];
    t_rgb r_middle_mem [MAX_WIDTH];
    t_rgb r_up_rd;
    t_rgb r_mid_rd;

    // registered read of both rows at the column of the accepted pixel
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_up_rd  <= r_upper_mem[i_rd_addr];
            r_mid_rd <= r_middle_mem[i_rd_addr];
        end
    end

    // rows move up by one: middle goes to upper, new pixel to middle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_upper_mem[i_wr_addr]  <= r_mid_rd;
            r_middle_mem[i_wr_addr] <= i_wr_px;
        end
    end

    assign o_up  = r_up_rd;
    assign o_mid = r_mid_rd;

endmodule

`default_nettype wire

FILE: rtl/sre_kernel.sv
`default_nettype none

module sre_kernel
    import sre_pkg::*;
(
    input  wire t_window    i_win,
    output logic [7:0]      o_red_edge,
    output logic [7:0]      o_green_edge,
    output logic [7:0]      o_blue_edge
);

    // |gh| + |gv| of one channel, saturated to 8 bits
    function automatic logic [7:0] edge_mag(input logic [2:0][2:0][7:0] p);
        logic [9:0]  hp;
        logic [9:0]  hn;
        logic [9:0]  vp;
        logic [9:0]  vn;
        logic [9:0]  gh;
        logic [9:0]  gv;
        logic [10:0] m;
        hp = {2'b00, p[0][2]} + {1'b0, p[1][2], 1'b0} + {2'b00, p[2][2]};
        hn = {2'b00, p[0][0]} + {1'b0, p[1][0], 1'b0} + {2'b00, p[2][0]};
        vp = {2'b00, p[2][0]} + {1'b0, p[2][1], 1'b0} + {2'b00, p[2][2]};
        vn = {2'b00, p[0][0]} + {1'b0, p[0][1], 1'b0} + {2'b00, p[0][2]};
        gh = (hp >= hn) ? (hp - hn) : (hn - hp);
        gv = (vp >= vn) ? (vp - vn) : (vn - vp);
        m  = {1'b0, gh} + {1'b0, gv};
        return (m > 11'd255) ? 8'hFF : m[7:0];
    endfunction

    logic [2:0][2:0][7:0] red_p;
    logic [2:0][2:0][7:0] green_p;
    logic [2:0][2:0][7:0] blue_p;

    // split the window into channel planes
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                red_p[r][c]   = i_win[r][c].red;
                green_p[r][c] = i_win[r][c].green;
                blue_p[r][c]  = i_win[r][c].blue;
            end
        end
    end

    assign o_red_edge   = edge_mag(red_p);
    assign o_green_edge = edge_mag(green_p);
    assign o_blue_edge  = edge_mag(blue_p);

endmodule

`default_nettype wire

FILE: rtl/sobel_rgb_edge_filter.sv
// sobel_rgb_edge_filter: 3x3 sobel edge magnitude on an rgb raster stream
//
// input channel: i_in_valid / o_in_stall / i_in_data, one pixel per
// transaction in raster order, column fastest. output channel:
// o_out_valid / i_out_stall / o_out_data, one transaction per interior
// pixel, carrying |gh|+|gv| per channel saturated to 255 and frame_done on
// the last interior pixel of the frame. border pixels give no output.
// configuration: i_cfg_we with i_cfg_index / i_cfg_data sets image width
// (index 0) and height (index 1); write only while the block is idle.
// throughput: one pixel per clock when not stalled, set by the single read
// and write port of each line store. a centre pixel's result passes stage 1,
// the window and output registers after its below-right pixel is accepted.
// a result is held in the output register until taken; while it is stalled
// the two earlier stages keep filling, and o_in_stall rises only once both
// hold an item that cannot move.
// synchronous reset clears the pipeline, the window and the position to
// row 0, column 0, and sets width 640 and height 480. line stores are not
// cleared; data read before it is written only reaches windows with no output.
`default_nettype none

module sobel_rgb_edge_filter
    import sre_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = SRE_MAX_WIDTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_pix_in     i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_pix_out         o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);

    // last column index of a row for a written width, the width clamped to 3..MAX_WIDTH
    function automatic logic [CW-1:0] col_last_of(input logic [11:0] w);
        if (w < 12'd3) begin
            return CW'(2);
        end else if (32'(w) > 32'(MAX_WIDTH)) begin
            return CW'(MAX_WIDTH - 1);
        end else begin
            return CW'(w - 12'd1);
        end
    endfunction

    // last row index of a frame for a written height, at least 3 rows
    function automatic logic [15:0] row_last_of(input logic [15:0] h);
        if (h < 16'd3) begin
            return 16'd2;
        end else begin
            return h - 16'd1;
        end
    endfunction

    logic [CW-1:0] r_col_last;
    logic [15:0]   r_row_last;
    logic [CW-1:0] r_col;
    logic [15:0]   r_row;

    logic          r_s1_valid;
    logic          r_s1_emit;
    logic          r_s1_done;
    logic [CW-1:0] r_s1_col;
    t_rgb          r_s1_px;

    logic          r_s2_valid;
    logic          r_s2_emit;
    logic          r_s2_done;
    t_window       r_win;
    t_window       n_win;

    logic          r_out_valid;
    t_pix_out      r_out_data;

    logic          in_accept;
    logic          s1_ready;
    logic          s1_move;
    logic          s2_ready;
    logic          s2_move;
    logic          out_load;
    logic          row_end;
    t_rgb          in_px;
    t_rgb          up_px;
    t_rgb          mid_px;
    logic [7:0]    red_edge;
    logic [7:0]    green_edge;
    logic [7:0]    blue_edge;

    // pipeline handshake
    assign s2_ready  = !r_s2_emit || !r_out_valid || !i_out_stall;
    assign s2_move   = r_s2_valid && s2_ready;
    assign s1_ready  = !r_s2_valid || s2_ready;
    assign s1_move   = r_s1_valid && s1_ready;
    assign o_in_stall = r_s1_valid && !s1_ready;
    assign in_accept = i_in_valid && !o_in_stall;
    assign out_load  = s2_move && r_s2_emit;
    assign row_end   = (r_col >= r_col_last);

    assign in_px = '{red: i_in_data.red_in, green: i_in_data.green_in,
                     blue: i_in_data.blue_in};

    // configuration registers, stored as clamped last indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= col_last_of(SRE_WIDTH_RESET);
            r_row_last <= row_last_of(SRE_HEIGHT_RESET);
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_IMAGE_WIDTH:  r_col_last <= col_last_of(i_cfg_data[11:0]);
                CFG_IMAGE_HEIGHT: r_row_last <= row_last_of(i_cfg_data);
                default:          r_col_last <= r_col_last;
            endcase
        end
    end

    // raster position of the next pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= (r_row >= r_row_last) ? 16'd0 : (r_row + 16'd1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // line stores, read on accept and written as the item enters the window
    sre_line_buffer #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buffer (
        .i_clk     (i_clk),
        .i_rd_en   (in_accept),
        .i_rd_addr (r_col),
        .i_wr_en   (s1_move),
        .i_wr_addr (r_s1_col),
        .i_wr_px   (r_s1_px),
        .o_up      (up_px),
        .o_mid     (mid_px)
    );

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_px   <= in_px;
            r_s1_col  <= r_col;
            r_s1_emit <= (r_row >= 16'd2) && (r_col >= CW'(2));
            r_s1_done <= (r_row >= r_row_last) && row_end;
        end
    end

    // window shift by one column
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = up_px;
        n_win[1][2] = mid_px;
        n_win[2][2] = r_s1_px;
    end

    // stage 2: window and its control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s2_emit  <= 1'b0;
            r_s2_done  <= 1'b0;
            r_win      <= '0;
        end else if (s1_move) begin
            r_s2_valid <= 1'b1;
            r_s2_emit  <= r_s1_emit;
            r_s2_done  <= r_s1_done;
            r_win      <= n_win;
        end else if (s2_move) begin
            r_s2_valid <= 1'b0;
            r_s2_emit  <= 1'b0;
        end
    end

    sre_kernel u_kernel (
        .i_win        (r_win),
        .o_red_edge   (red_edge),
        .o_green_edge (green_edge),
        .o_blue_edge  (blue_edge)
    );

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= '{red_edge: red_edge, green_edge: green_edge,
                            blue_edge: blue_edge, frame_done: r_s2_done};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

FILE: rtl/sre_checker.sv
`default_nettype none

module sre_checker
    import sre_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire t_pix_in     i_in_data,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire t_pix_out    o_out_data
);

    // reset empties the pipeline and opens the input
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    // input only backs up when a result is waiting on a stalled receiver
    a_stall_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output is free");

    // input never stalls while nothing is waiting at the output
    a_no_stall_idle_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while output is empty");

    // a stalled input transaction stays offered and unchanged
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("stalled input transaction changed");

    // a stalled result stays valid and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output transaction changed");

endmodule

bind sobel_rgb_edge_filter sre_checker u_sre_checker (.*);

`default_nettype wire
